// ----- rtl/pdm_pkg.sv -----
// shared types and constants for the periodic deadline monitor
// used by every module under rtl; no dependencies
`default_nettype none

package pdm_pkg;

  localparam int PERIOD_W       = 40;
  localparam int FIELD_W        = 63;
  localparam int CALC_W         = 64;
  localparam int TIME_WIDTH_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd1000000;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_REPORT = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [FIELD_W-1:0] wake;
    logic [FIELD_W-1:0] fin;
  } item_t;

  typedef struct packed {
    logic              go;
    logic [CALC_W-1:0] dividend;
    logic [CALC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CALC_W-1:0] quot;
    logic [CALC_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [FIELD_W-1:0] sequence_res;
    logic [FIELD_W-1:0] deadline_ns;
    logic [FIELD_W-1:0] wake_late_ns;
    logic [FIELD_W-1:0] missed_now;
    logic [FIELD_W-1:0] cycle_count;
    logic [FIELD_W-1:0] miss_total;
    logic [FIELD_W-1:0] min_late_ns;
    logic [FIELD_W-1:0] max_late_ns;
    logic [FIELD_W-1:0] mean_late_ns;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/pdm_front.sv -----
// front end: takes input transactions, classifies the op and trims times
// to the configured time width; depends on pdm_pkg
`default_nettype none

module pdm_front #(
  parameter int TIME_WIDTH = pdm_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                        in_valid,
  input  wire logic                        in_op,
  input  wire logic [pdm_pkg::FIELD_W-1:0] in_wake_ns,
  input  wire logic [pdm_pkg::FIELD_W-1:0] in_finish_ns,
  output logic                             in_stall,
  input  wire logic                        q_full,
  output logic                             q_push,
  output pdm_pkg::item_t                   q_item
);

  localparam int KEEP_W = (TIME_WIDTH < pdm_pkg::FIELD_W) ? TIME_WIDTH : pdm_pkg::FIELD_W;
  localparam logic [pdm_pkg::FIELD_W-1:0] TIME_MASK =
    {(pdm_pkg::FIELD_W){1'b1}} >> (pdm_pkg::FIELD_W - KEEP_W);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.kind = in_op ? pdm_pkg::OP_REPORT : pdm_pkg::OP_START;
    q_item.wake = in_wake_ns & TIME_MASK;
    q_item.fin  = (in_op ? in_finish_ns : '0) & TIME_MASK;
  end

endmodule

`default_nettype wire

// ----- rtl/pdm_queue.sv -----
// short transaction queue between front end and back end
// depends on pdm_pkg for the entry type and depth
`default_nettype none

module pdm_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  pdm_pkg::item_t      din,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output pdm_pkg::item_t      dout
);

  localparam int PTR_W = (pdm_pkg::QUEUE_DEPTH > 1) ? $clog2(pdm_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pdm_pkg::QUEUE_DEPTH + 1);

  pdm_pkg::item_t mem_r [pdm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(pdm_pkg::QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(pdm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(pdm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(pdm_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/pdm_div.sv -----
// shared iterative unsigned divider, one quotient bit per cycle
// depends on pdm_pkg for the request and response types
`default_nettype none

module pdm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  pdm_pkg::div_req_t req,
  output pdm_pkg::div_rsp_t rsp
);

  localparam int W     = pdm_pkg::CALC_W;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     q_r, q_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     d_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       shifted;
  logic [W:0]       sub;
  logic             ge;

  assign shifted = {rem_r, q_r[W-1]};
  assign sub     = shifted - {1'b0, d_r};
  assign ge      = (shifted >= {1'b0, d_r});

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.go) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[W-2:0], ge};
      rem_nxt = ge ? sub[W-1:0] : shifted[W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (req.go) begin
      d_r <= req.divisor;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !busy_r)
    else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

// ----- rtl/pdm_back.sv -----
// back end: deadline state, statistics, sequencing of the two divisions
// and the result register; depends on pdm_pkg and drives pdm_div
`default_nettype none

module pdm_back #(
  parameter int TIME_WIDTH = pdm_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pdm_pkg::PERIOD_W-1:0] cfg_period_ns,
  input  wire logic                         q_valid,
  input  pdm_pkg::item_t                    q_item,
  output logic                              q_pop,
  output pdm_pkg::div_req_t                 div_req,
  input  pdm_pkg::div_rsp_t                 div_rsp,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output pdm_pkg::res_t                     out_res
);

  localparam int W  = pdm_pkg::CALC_W;
  localparam int FW = pdm_pkg::FIELD_W;
  localparam int TW = TIME_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MISS,
    ST_MEAN,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [pdm_pkg::PERIOD_W-1:0] per_r, per_nxt;
  logic [TW-1:0] ndl_r, ndl_nxt;
  logic [W-1:0]  tick_r, tick_nxt;
  logic [W-1:0]  cyc_r, cyc_nxt;
  logic [W-1:0]  miss_r, miss_nxt;
  logic [W-1:0]  least_r, least_nxt;
  logic [W-1:0]  most_r, most_nxt;
  logic [W-1:0]  sum_r, sum_nxt;
  logic [TW-1:0] cur_dl_r, cur_dl_nxt;
  logic [TW-1:0] cur_fin_r, cur_fin_nxt;
  logic          use_miss_r, use_miss_nxt;
  logic          out_valid_r, out_valid_nxt;
  pdm_pkg::res_t     res_r, res_nxt;
  pdm_pkg::div_req_t req_r, req_nxt;

  logic [pdm_pkg::PERIOD_W-1:0] per_eff;
  logic [W-1:0]  per64;
  logic [TW-1:0] wake_t, fin_t, late_t, diff_t;
  logic [W-1:0]  late64, diff64, cyc_inc, missed64;

  assign cfg_ready = 1'b1;
  assign per_eff   = (per_r == '0) ? pdm_pkg::PERIOD_W'(1) : per_r;
  assign per64     = W'(per_eff);
  assign wake_t    = TW'(q_item.wake);
  assign fin_t     = TW'(q_item.fin);
  assign late_t    = (wake_t > ndl_r) ? wake_t - ndl_r : '0;
  assign diff_t    = (fin_t > ndl_r) ? fin_t - ndl_r : '0;
  assign late64    = W'(late_t);
  assign diff64    = W'(diff_t);
  assign cyc_inc   = cyc_r + 1'b1;
  assign missed64  = use_miss_r ? div_rsp.quot : '0;

  always_comb begin
    state_nxt     = state_r;
    per_nxt       = per_r;
    ndl_nxt       = ndl_r;
    tick_nxt      = tick_r;
    cyc_nxt       = cyc_r;
    miss_nxt      = miss_r;
    least_nxt     = least_r;
    most_nxt      = most_r;
    sum_nxt       = sum_r;
    cur_dl_nxt    = cur_dl_r;
    cur_fin_nxt   = cur_fin_r;
    use_miss_nxt  = use_miss_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    req_nxt       = req_r;
    req_nxt.go    = 1'b0;
    q_pop         = 1'b0;

    if (cfg_valid) begin
      per_nxt = cfg_period_ns;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.kind)
            pdm_pkg::OP_START: begin
              ndl_nxt       = TW'(W'(wake_t) + per64);
              tick_nxt      = '0;
              cyc_nxt       = '0;
              miss_nxt      = '0;
              least_nxt     = '0;
              most_nxt      = '0;
              sum_nxt       = '0;
              res_nxt       = '0;
              res_nxt.deadline_ns = FW'(W'(TW'(W'(wake_t) + per64)));
              out_valid_nxt = 1'b1;
              state_nxt     = ST_OUT;
            end
            pdm_pkg::OP_REPORT: begin
              cyc_nxt   = cyc_inc;
              least_nxt = (cyc_inc == W'(1) || late64 < least_r) ? late64 : least_r;
              most_nxt  = (late64 > most_r) ? late64 : most_r;
              sum_nxt   = sum_r + late64;
              tick_nxt  = tick_r + 1'b1;
              cur_dl_nxt   = ndl_r;
              cur_fin_nxt  = fin_t;
              use_miss_nxt = (diff64 >= per64);
              res_nxt.sequence_res = FW'(tick_r + 1'b1);
              res_nxt.deadline_ns  = FW'(W'(ndl_r));
              res_nxt.wake_late_ns = FW'(late64);
              req_nxt.go       = 1'b1;
              req_nxt.dividend = diff64;
              req_nxt.divisor  = per64;
              state_nxt        = ST_MISS;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MISS: begin
        if (div_rsp.done) begin
          miss_nxt = miss_r + missed64;
          res_nxt.missed_now = FW'(missed64);
          if (use_miss_r) begin
            ndl_nxt = TW'(W'(cur_fin_r) - div_rsp.rem + per64);
          end else begin
            ndl_nxt = TW'(W'(cur_dl_r) + per64);
          end
          req_nxt.go       = 1'b1;
          req_nxt.dividend = sum_r;
          req_nxt.divisor  = cyc_r;
          state_nxt        = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (div_rsp.done) begin
          res_nxt.cycle_count  = FW'(cyc_r);
          res_nxt.miss_total   = FW'(miss_r);
          res_nxt.min_late_ns  = FW'(least_r);
          res_nxt.max_late_ns  = FW'(most_r);
          res_nxt.mean_late_ns = (cyc_r == '0) ? '0 : FW'(div_rsp.quot);
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_dl_r         <= cur_dl_nxt;
    cur_fin_r        <= cur_fin_nxt;
    use_miss_r       <= use_miss_nxt;
    res_r            <= res_nxt;
    req_r.dividend   <= req_nxt.dividend;
    req_r.divisor    <= req_nxt.divisor;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      per_r       <= pdm_pkg::PERIOD_RESET;
      ndl_r       <= '0;
      tick_r      <= '0;
      cyc_r       <= '0;
      miss_r      <= '0;
      least_r     <= '0;
      most_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      req_r.go    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      per_r       <= per_nxt;
      ndl_r       <= ndl_nxt;
      tick_r      <= tick_nxt;
      cyc_r       <= cyc_nxt;
      miss_r      <= miss_nxt;
      least_r     <= least_nxt;
      most_r      <= most_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      req_r.go    <= req_nxt.go;
    end
  end

  assign div_req   = req_r;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

`ifndef SYNTHESIS
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    least_r <= most_r)
    else $error("minimum lateness above maximum");
  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_OUT)
    else $error("result valid outside output state");
`endif

endmodule

`default_nettype wire

// ----- rtl/periodic_deadline_monitor_core.sv -----
// top level of the periodic deadline monitor: front end, queue, back end
// and shared divider; depends on pdm_pkg, pdm_front, pdm_queue, pdm_div, pdm_back
//
// A start transaction seeds the deadline and clears the statistics; its
// result is registered once the back end pops it from the queue, and the
// back end is free for the next one in the cycle after the result is taken. A
// report transaction holds the back end until its result is taken: two 64-bit
// divisions (missed periods, then mean lateness) run one after the other on a
// single shared divider that retires one quotient bit per cycle, then the
// result waits in the output state for the handshake, and the back end then
// takes the next transaction from the queue. A result is held while out_stall
// is high. The back end works on one transaction at a time; a two-entry queue
// in front of it keeps accepting input while a result waits on out_stall, and
// in_stall is high while that queue is full. cfg_ready is always high, and the
// period should only be written while the block is idle.
`default_nettype none

module periodic_deadline_monitor_core #(
  parameter int TIME_WIDTH = pdm_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pdm_pkg::PERIOD_W-1:0] cfg_period_ns,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_op,
  input  wire logic [pdm_pkg::FIELD_W-1:0]  in_wake_ns,
  input  wire logic [pdm_pkg::FIELD_W-1:0]  in_finish_ns,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [pdm_pkg::FIELD_W-1:0]       out_sequence_res,
  output logic [pdm_pkg::FIELD_W-1:0]       out_deadline_ns,
  output logic [pdm_pkg::FIELD_W-1:0]       out_wake_late_ns,
  output logic [pdm_pkg::FIELD_W-1:0]       out_missed_now,
  output logic [pdm_pkg::FIELD_W-1:0]       out_cycle_count,
  output logic [pdm_pkg::FIELD_W-1:0]       out_miss_total,
  output logic [pdm_pkg::FIELD_W-1:0]       out_min_late_ns,
  output logic [pdm_pkg::FIELD_W-1:0]       out_max_late_ns,
  output logic [pdm_pkg::FIELD_W-1:0]       out_mean_late_ns
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  pdm_pkg::item_t    q_din;
  pdm_pkg::item_t    q_dout;
  pdm_pkg::div_req_t div_req;
  pdm_pkg::div_rsp_t div_rsp;
  pdm_pkg::res_t     res;

  pdm_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .in_valid    (in_valid),
    .in_op       (in_op),
    .in_wake_ns  (in_wake_ns),
    .in_finish_ns(in_finish_ns),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_din)
  );

  pdm_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .dout (q_dout)
  );

  pdm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  pdm_back #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_period_ns(cfg_period_ns),
    .q_valid      (q_valid),
    .q_item       (q_dout),
    .q_pop        (q_pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  assign out_sequence_res = res.sequence_res;
  assign out_deadline_ns  = res.deadline_ns;
  assign out_wake_late_ns = res.wake_late_ns;
  assign out_missed_now   = res.missed_now;
  assign out_cycle_count  = res.cycle_count;
  assign out_miss_total   = res.miss_total;
  assign out_min_late_ns  = res.min_late_ns;
  assign out_max_late_ns  = res.max_late_ns;
  assign out_mean_late_ns = res.mean_late_ns;

endmodule

`default_nettype wire
